// ----- rtl/core/cews_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cews_pkg
// shared constants and types for the cycle edge weight sum block
// ----------------------------------------------------------------------------
package cews_pkg;

  localparam int MaxEdges    = 4096;
  localparam int MaxVertices = 1024;
  localparam int EdgeAw      = $clog2(MaxEdges);
  localparam int VtxW        = $clog2(MaxVertices);
  localparam int CntW        = EdgeAw + 1;
  localparam int SizeW       = VtxW + 1;
  localparam int WeightW     = 32;
  localparam int SumW        = 44;
  localparam int AccW        = 48;

  typedef logic [VtxW-1:0]           vtx_t;
  typedef logic signed [WeightW-1:0] weight_t;

  typedef struct packed {
    vtx_t    src;
    vtx_t    dst;
    weight_t weight;
  } edge_t;

  localparam logic [1:0] StatusOk       = 2'd0;
  localparam logic [1:0] StatusOverflow = 2'd1;
  localparam logic [1:0] StatusRange    = 2'd2;

  // edge sort compare: a goes before b
  function automatic logic heavier(input weight_t a, input weight_t b);
    heavier = a > b;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/cews_sorter.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cews_sorter
// edge store with insertion sort by descending weight; one ram, shifting entries
// down one place per read and compare, then streams the sorted edges on request
// ----------------------------------------------------------------------------
module cews_sorter (
  input  wire                          clk,
  input  wire                          rst_n,
  // insert request
  input  wire                          ins_valid,
  output logic                         ins_ready,
  input  cews_pkg::edge_t              ins_edge,
  input  wire  [cews_pkg::CntW-1:0]    total,
  // read port for the union-find pass
  input  wire                          rd_en,
  input  wire  [cews_pkg::EdgeAw-1:0]  rd_addr,
  output cews_pkg::edge_t              rd_edge
);

  typedef enum logic [1:0] {S_IDLE, S_READ, S_CMP} state_t;

  cews_pkg::edge_t mem [cews_pkg::MaxEdges];
  cews_pkg::edge_t rdata_r;

  state_t                     state_r;
  logic [cews_pkg::CntW-1:0]  pos_r;
  cews_pkg::edge_t            new_r;

  logic                       we;
  logic [cews_pkg::EdgeAw-1:0] waddr;
  cews_pkg::edge_t            wdata;
  logic                       re;
  logic [cews_pkg::EdgeAw-1:0] raddr;

  always_comb begin
    we    = 1'b0;
    waddr = pos_r[cews_pkg::EdgeAw-1:0];
    wdata = new_r;
    re    = rd_en;
    raddr = rd_addr;
    case (state_r)
      S_IDLE: begin
        if (ins_valid && total == '0) begin
          we    = 1'b1;
          waddr = '0;
          wdata = ins_edge;
        end else if (ins_valid) begin
          re    = 1'b1;
          raddr = cews_pkg::EdgeAw'(total - 1'b1);
        end
      end
      // every entry moved down, new edge lands in slot zero
      S_READ: we = (pos_r == '0);
      S_CMP: begin
        we = 1'b1;
        if (cews_pkg::heavier(new_r.weight, rdata_r.weight)) begin
          // shift the lighter edge one place down
          wdata = rdata_r;
          if (pos_r != 1) begin
            re    = 1'b1;
            raddr = cews_pkg::EdgeAw'(pos_r - 2'd2);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_r <= mem[raddr];
  end

  assign rd_edge   = rdata_r;
  assign ins_ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pos_r   <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (ins_valid && total != '0) begin
            new_r   <= ins_edge;
            pos_r   <= total;
            state_r <= S_READ;
          end
        end
        S_READ: state_r <= (pos_r == '0) ? S_IDLE : S_CMP;
        S_CMP: begin
          if (cews_pkg::heavier(new_r.weight, rdata_r.weight)) begin
            pos_r   <= pos_r - 1'b1;
            state_r <= S_READ;
          end else begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/cews_uf.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cews_uf
// union-find engine: parent and size rams, root walk with path compression,
// union by size, accumulates weights of cycle-closing edges
// ----------------------------------------------------------------------------
module cews_uf (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                start,
  input  wire  [cews_pkg::CntW-1:0]          total,
  output logic                               edge_rd,
  output logic [cews_pkg::EdgeAw-1:0]        edge_addr,
  input  cews_pkg::edge_t                    edge_in,
  output logic                               done,
  output logic signed [cews_pkg::SumW-1:0]   sum
);

  typedef enum logic [3:0] {
    U_IDLE, U_CLEAR, U_FETCH, U_LATCH, U_FIND, U_FCHK, U_COMP, U_CCHK, U_NEXT,
    U_SZRD, U_SZWAIT, U_UNION, U_DONE
  } state_t;

  localparam logic signed [cews_pkg::AccW-1:0] SumMax =
    cews_pkg::AccW'(64'sd8796093022207);
  localparam logic signed [cews_pkg::AccW-1:0] SumMin =
    -cews_pkg::AccW'(64'sd8796093022207) - 1;

  cews_pkg::vtx_t               par_mem [cews_pkg::MaxVertices];
  logic [cews_pkg::SizeW-1:0]   sz_mem  [cews_pkg::MaxVertices];
  cews_pkg::vtx_t               par_q_r;
  logic [cews_pkg::SizeW-1:0]   sz_q_r;

  state_t                           state_r;
  logic [cews_pkg::CntW-1:0]        idx_r;
  cews_pkg::vtx_t                   clr_r;
  cews_pkg::edge_t                  e_r;
  logic                             side_r;    // 0 src, 1 dst
  cews_pkg::vtx_t                   cur_r;
  cews_pkg::vtx_t                   root_a_r;
  cews_pkg::vtx_t                   root_b_r;
  logic [cews_pkg::SizeW-1:0]       sz_a_r;
  logic                             szb_r;
  logic signed [cews_pkg::AccW-1:0] acc_r;

  logic                             p_we, p_re, s_we, s_re;
  cews_pkg::vtx_t                   p_wa, p_wd, p_ra, s_wa, s_ra;
  logic [cews_pkg::SizeW-1:0]       s_wd;
  cews_pkg::vtx_t                   start_v;

  assign start_v = side_r ? e_r.dst : e_r.src;

  always_comb begin
    p_we = 1'b0; p_wa = clr_r; p_wd = clr_r;
    s_we = 1'b0; s_wa = clr_r; s_wd = cews_pkg::SizeW'(1);
    p_re = 1'b0; p_ra = cur_r;
    s_re = 1'b0; s_ra = root_a_r;
    case (state_r)
      U_CLEAR: begin p_we = 1'b1; s_we = 1'b1; end
      U_FIND:  p_re = 1'b1;
      U_COMP:  p_re = 1'b1;
      U_CCHK: begin
        if (par_q_r != root_a_r) begin
          p_we = 1'b1; p_wa = cur_r; p_wd = root_a_r;
        end
      end
      U_SZRD: begin s_re = 1'b1; s_ra = szb_r ? root_b_r : root_a_r; end
      U_UNION: begin
        p_we = 1'b1; s_we = 1'b1;
        // sz_a_r is the dst set, sz_q_r the src set; ties keep the src root
        if (sz_q_r < sz_a_r) begin
          p_wa = root_b_r; p_wd = root_a_r; s_wa = root_a_r;
        end else begin
          p_wa = root_a_r; p_wd = root_b_r; s_wa = root_b_r;
        end
        s_wd = sz_a_r + sz_q_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (p_we) par_mem[p_wa] <= p_wd;
    if (p_re) par_q_r <= par_mem[p_ra];
    if (s_we) sz_mem[s_wa] <= s_wd;
    if (s_re) sz_q_r <= sz_mem[s_ra];
  end

  assign edge_rd   = (state_r == U_FETCH);
  assign edge_addr = idx_r[cews_pkg::EdgeAw-1:0];
  assign done      = (state_r == U_DONE);
  assign sum       = (acc_r > SumMax) ? cews_pkg::SumW'(SumMax) :
                     (acc_r < SumMin) ? cews_pkg::SumW'(SumMin) :
                     cews_pkg::SumW'(acc_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= U_IDLE;
      clr_r   <= '0;
      idx_r   <= '0;
      acc_r   <= '0;
      side_r  <= 1'b0;
      szb_r   <= 1'b0;
    end else begin
      case (state_r)
        U_IDLE: if (start) begin
          clr_r <= '0; idx_r <= '0; acc_r <= '0; state_r <= U_CLEAR;
        end
        U_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (&clr_r) state_r <= (total == '0) ? U_DONE : U_FETCH;
        end
        U_FETCH: state_r <= U_LATCH;
        U_LATCH: begin
          e_r <= edge_in; side_r <= 1'b0; cur_r <= edge_in.src; state_r <= U_FIND;
        end
        U_FIND: state_r <= U_FCHK;
        U_FCHK: begin
          if (par_q_r == cur_r) begin
            // root found, restart walk to compress
            root_a_r <= cur_r; cur_r <= start_v; state_r <= U_COMP;
          end else begin
            cur_r <= par_q_r; state_r <= U_FIND;
          end
        end
        U_COMP: state_r <= U_CCHK;
        U_CCHK: begin
          if (par_q_r != root_a_r && cur_r != root_a_r) begin
            cur_r <= par_q_r; state_r <= U_COMP;
          end else if (!side_r) begin
            root_b_r <= root_a_r; side_r <= 1'b1; cur_r <= e_r.dst;
            state_r <= U_FIND;
          end else begin
            state_r <= U_NEXT;
          end
        end
        U_NEXT: begin
          // root_b_r holds src root, root_a_r holds dst root
          if (root_a_r == root_b_r) begin
            acc_r   <= acc_r + cews_pkg::AccW'(e_r.weight);
            state_r <= (idx_r + 1'b1 == total) ? U_DONE : U_FETCH;
            idx_r   <= idx_r + 1'b1;
          end else begin
            szb_r <= 1'b0; state_r <= U_SZRD;
          end
        end
        U_SZRD: state_r <= U_SZWAIT;
        U_SZWAIT: begin
          if (!szb_r) begin
            sz_a_r <= sz_q_r; szb_r <= 1'b1; state_r <= U_SZRD;
          end else begin
            state_r <= U_UNION;
          end
        end
        U_UNION: begin
          idx_r   <= idx_r + 1'b1;
          state_r <= (idx_r + 1'b1 == total) ? U_DONE : U_FETCH;
        end
        U_DONE: state_r <= U_IDLE;
        default: state_r <= U_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/cycle_edge_weight_sum.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cycle_edge_weight_sum
// total weight of edges outside a maximum spanning forest
// ----------------------------------------------------------------------------
// Edges arrive as beats on the in_ channel; in_last_edge closes a graph.
// Each edge is insertion sorted into a 4096-entry ram by descending weight:
// every stored edge lighter than it is shifted one place down in the ram, an
// edge into an empty store is written directly, and a new edge is taken only
// once the last is stored. After the last edge the union-find engine clears
// the 1024-entry parent and size rams, then walks the sorted edges, with a
// find walk and a compression walk along the parent pointers per endpoint.
// One beat then appears on out_ with the saturated sum and status; it holds
// until taken, and no new edge is accepted until then. Out-of-range or
// overflowing edges are dropped and flagged. cfg_ writes vertex_count and
// are only to be made while the block is idle. Reset (synchronous, rst_n
// low) empties the store, clears the flags and sets vertex_count to 1023.
// ----------------------------------------------------------------------------
module cycle_edge_weight_sum (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [9:0]  cfg_vertex_count,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [9:0]  in_src_vertex,
  input  wire  [9:0]  in_dst_vertex,
  input  wire  [31:0] in_edge_weight,
  input  wire         in_last_edge,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [43:0] out_cycle_weight_sum,
  output logic [1:0]  out_status
);

  typedef enum logic [2:0] {T_ACCEPT, T_INSERT, T_START, T_RUN, T_OUT} state_t;

  state_t                        state_r;
  logic [9:0]                    vcount_r;
  logic [cews_pkg::CntW-1:0]     total_r;
  logic [1:0]                    err_r;
  logic                          last_r;
  cews_pkg::edge_t               edge_r;
  logic                          ins_valid, ins_ready;
  logic                          uf_done, uf_rd;
  logic [cews_pkg::EdgeAw-1:0]   uf_addr;
  cews_pkg::edge_t               rd_edge;
  logic signed [cews_pkg::SumW-1:0] uf_sum;
  logic                          bad_vtx, full;
  logic                          sort_busy_r;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == T_ACCEPT);
  assign out_valid = (state_r == T_OUT);
  assign bad_vtx   = (in_src_vertex > vcount_r) || (in_dst_vertex > vcount_r);
  assign full      = total_r >= cews_pkg::CntW'(cews_pkg::MaxEdges);
  assign out_status = err_r[1] ? cews_pkg::StatusRange :
                      err_r[0] ? cews_pkg::StatusOverflow : cews_pkg::StatusOk;
  assign ins_valid = (state_r == T_INSERT) && !sort_busy_r;

  cews_sorter u_sorter (
    .clk, .rst_n,
    .ins_valid (ins_valid),
    .ins_ready (ins_ready),
    .ins_edge  (edge_r),
    .total     (total_r),
    .rd_en     (uf_rd),
    .rd_addr   (uf_addr),
    .rd_edge   (rd_edge)
  );

  cews_uf u_uf (
    .clk, .rst_n,
    .start     (state_r == T_START),
    .total     (total_r),
    .edge_rd   (uf_rd),
    .edge_addr (uf_addr),
    .edge_in   (rd_edge),
    .done      (uf_done),
    .sum       (uf_sum)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_ACCEPT;
      vcount_r    <= 10'd1023;
      total_r     <= '0;
      err_r       <= '0;
      last_r      <= 1'b0;
      sort_busy_r <= 1'b0;
    end else begin
      if (cfg_valid) vcount_r <= cfg_vertex_count;
      case (state_r)
        T_ACCEPT: if (in_valid) begin
          edge_r <= '{src: in_src_vertex, dst: in_dst_vertex, weight: in_edge_weight};
          last_r <= in_last_edge;
          if (bad_vtx) begin
            err_r[1] <= 1'b1;
            state_r  <= in_last_edge ? T_START : T_ACCEPT;
          end else if (full) begin
            err_r[0] <= 1'b1;
            state_r  <= in_last_edge ? T_START : T_ACCEPT;
          end else begin
            state_r <= T_INSERT;
          end
        end
        T_INSERT: begin
          if (!sort_busy_r) begin
            if (total_r == '0) begin
              // empty store, written directly
              total_r <= total_r + 1'b1;
              state_r <= last_r ? T_START : T_ACCEPT;
            end else begin
              sort_busy_r <= 1'b1;
            end
          end else if (ins_ready) begin
            total_r     <= total_r + 1'b1;
            sort_busy_r <= 1'b0;
            state_r     <= last_r ? T_START : T_ACCEPT;
          end
        end
        T_START: state_r <= T_RUN;
        T_RUN: if (uf_done) begin
          out_cycle_weight_sum <= uf_sum;
          state_r <= T_OUT;
        end
        T_OUT: if (out_ready) begin
          total_r <= '0; err_r <= '0; state_r <= T_ACCEPT;
        end
        default: state_r <= T_ACCEPT;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= cews_pkg::CntW'(cews_pkg::MaxEdges))
    else $error("edge count beyond store depth");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_cycle_weight_sum))
    else $error("result changed while stalled");
  a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input taken while result pending");
`endif

endmodule
`default_nettype wire
